// File: sv/cfet_pkg.sv
// ----------------------------------------------------------------------------
// cfet_pkg
// Shared types and constants of the coalescing free extent table.
// ----------------------------------------------------------------------------
package cfet_pkg;

  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned ENTRY_W = 96;

  typedef enum logic [1:0] {
    KIND_FREE   = 2'd0,
    KIND_ALLOC  = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    STATUS_OK      = 3'd0,
    STATUS_NO_FIT  = 3'd1,
    STATUS_FULL    = 3'd2,
    STATUS_ZERO    = 3'd3,
    STATUS_OVERLAP = 3'd4,
    STATUS_MISS    = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_EVAL,
    S_COMMIT
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic scan;
    logic eval;
    logic commit;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_last;
  } stat_t;

endpackage

// File: sv/cfet_ram.sv
// ----------------------------------------------------------------------------
// cfet_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module cfet_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: sv/cfet_ctrl.sv
// ----------------------------------------------------------------------------
// cfet_ctrl
// Sequencer: accept, scan the table, evaluate, commit and answer.
// ----------------------------------------------------------------------------
module cfet_ctrl import cfet_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  busy
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (start) state_d = S_SCAN;
      S_SCAN:   if (stat_i.scan_last) state_d = S_DRAIN;
      S_DRAIN:  state_d = S_EVAL;
      S_EVAL:   state_d = S_COMMIT;
      S_COMMIT: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      S_SCAN:   cmd_o.scan   = 1'b1;
      S_DRAIN:  ;
      S_EVAL:   cmd_o.eval   = 1'b1;
      S_COMMIT: cmd_o.commit = 1'b1;
      default:  ;
    endcase
  end

endmodule

// File: sv/cfet_dpath.sv
// ----------------------------------------------------------------------------
// cfet_dpath
// Table storage, scan comparators, decision and result registers.
// ----------------------------------------------------------------------------
module cfet_dpath import cfet_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output stat_t            stat_o,
  input  logic [1:0]       kind_i,
  input  logic [31:0]      extent_offset_i,
  input  logic [31:0]      extent_span_i,
  output logic             done_o,
  output logic [2:0]       status_o,
  output logic [31:0]      result_offset_o,
  output logic [31:0]      result_span_o,
  output logic [CNT_W-1:0] entry_count_o
);

  // request word
  kind_e       kind_q;
  logic [31:0] off_q, span_q;

  // persistent state
  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;
  logic [31:0]              ins_cnt_q;
  logic [CNT_W-1:0]         held_q, held_d;

  // scan
  logic [IDX_W-1:0] scan_cnt_q, rd_idx_q;
  logic             rd_pend_q;
  logic [ENTRY_W-1:0] rdata;
  logic [31:0]      e_off, e_span, e_age;
  logic             e_vld;

  // scan results
  logic             at_f_q, lo_f_q, hi_f_q, ff_f_q, b_f_q;
  logic [IDX_W-1:0] at_idx_q, lo_idx_q, hi_idx_q, ff_idx_q, b_idx_q;
  logic [31:0]      at_span_q, lo_off_q, lo_span_q, hi_off_q, hi_span_q;
  logic [31:0]      b_off_q, b_span_q, b_age_q;

  // decision
  status_e          st_q, st_c;
  logic [31:0]      ro_q, rs_q, ro_c, rs_c;
  logic             wr_q, wr_c, da_q, da_c, db_q, db_c;
  logic [IDX_W-1:0] slot_q, slot_c, dai_q, dai_c, dbi_q, dbi_c;

  // output registers
  logic             done_q;
  status_e          out_st_q;
  logic [31:0]      out_off_q, out_span_q;

  logic [32:0] req_end, lo_end;
  logic        jlo, jhi, ovl;
  logic [IDX_W-1:0] slot_t;

  assign stat_o.scan_last = (scan_cnt_q == IDX_W'(TABLE_ENTRIES - 1));

  cfet_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit & wr_q),
    .waddr_i (slot_q),
    .wdata_i ({ro_q, rs_q, ins_cnt_q}),
    .raddr_i (scan_cnt_q),
    .rdata_o (rdata)
  );

  assign e_off  = rdata[95:64];
  assign e_span = rdata[63:32];
  assign e_age  = ins_cnt_q - rdata[31:0];
  assign e_vld  = valid_q[rd_idx_q];

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_e'(kind_i);
      off_q  <= extent_offset_i;
      span_q <= extent_span_i;
    end
  end

  // scan address and read tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_cnt_q <= '0;
      rd_idx_q   <= '0;
      rd_pend_q  <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.scan;
      rd_idx_q  <= scan_cnt_q;
      if (cmd_i.load) begin
        scan_cnt_q <= '0;
      end else if (cmd_i.scan) begin
        scan_cnt_q <= scan_cnt_q + 1'b1;
      end
    end
  end

  // per entry comparisons while scanning
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      at_f_q <= 1'b0;
      lo_f_q <= 1'b0;
      hi_f_q <= 1'b0;
      ff_f_q <= 1'b0;
      b_f_q  <= 1'b0;
    end else if (rd_pend_q) begin
      if (!e_vld && !ff_f_q) begin
        ff_f_q   <= 1'b1;
        ff_idx_q <= rd_idx_q;
      end
      if (e_vld && e_off == off_q) begin
        at_f_q    <= 1'b1;
        at_idx_q  <= rd_idx_q;
        at_span_q <= e_span;
      end
      if (e_vld && e_off < off_q && (!lo_f_q || e_off > lo_off_q)) begin
        lo_f_q    <= 1'b1;
        lo_idx_q  <= rd_idx_q;
        lo_off_q  <= e_off;
        lo_span_q <= e_span;
      end
      if (e_vld && e_off > off_q && (!hi_f_q || e_off < hi_off_q)) begin
        hi_f_q    <= 1'b1;
        hi_idx_q  <= rd_idx_q;
        hi_off_q  <= e_off;
        hi_span_q <= e_span;
      end
      if (e_vld && e_span >= span_q &&
          (!b_f_q || e_span < b_span_q || (e_span == b_span_q && e_age > b_age_q))) begin
        b_f_q    <= 1'b1;
        b_idx_q  <= rd_idx_q;
        b_off_q  <= e_off;
        b_span_q <= e_span;
        b_age_q  <= e_age;
      end
    end
  end

  // free request geometry
  assign req_end = {1'b0, off_q} + {1'b0, span_q};
  assign lo_end  = {1'b0, lo_off_q} + {1'b0, lo_span_q};
  assign jlo     = lo_f_q && (lo_end == {1'b0, off_q});
  assign jhi     = hi_f_q && (req_end == {1'b0, hi_off_q});
  assign ovl     = at_f_q || (lo_f_q && lo_end > {1'b0, off_q})
                          || (hi_f_q && req_end > {1'b0, hi_off_q});

  // lowest free slot once the merged neighbors are gone
  always_comb begin
    slot_t = ff_f_q ? ff_idx_q : {IDX_W{1'b1}};
    if (jhi && hi_idx_q < slot_t) slot_t = hi_idx_q;
    if (jlo && lo_idx_q < slot_t) slot_t = lo_idx_q;
  end

  // decision
  always_comb begin
    st_c   = STATUS_OK;
    ro_c   = '0;
    rs_c   = '0;
    wr_c   = 1'b0;
    da_c   = 1'b0;
    db_c   = 1'b0;
    dai_c  = hi_idx_q;
    dbi_c  = lo_idx_q;
    slot_c = slot_t;
    case (kind_q)
      KIND_FREE: begin
        if (off_q == '0 || span_q == '0) begin
          st_c = STATUS_ZERO;
        end else if (req_end[32] || ovl) begin
          st_c = STATUS_OVERLAP;
        end else if (!jlo && !jhi && held_q == CNT_W'(TABLE_ENTRIES)) begin
          st_c = STATUS_FULL;
        end else begin
          wr_c = 1'b1;
          da_c = jhi;
          db_c = jlo;
          ro_c = jlo ? lo_off_q : off_q;
          rs_c = span_q + (jhi ? hi_span_q : 32'd0) + (jlo ? lo_span_q : 32'd0);
        end
      end
      KIND_ALLOC: begin
        dai_c = b_idx_q;
        if (span_q == '0) begin
          st_c = STATUS_ZERO;
        end else if (!b_f_q) begin
          st_c = STATUS_NO_FIT;
        end else begin
          da_c = 1'b1;
          ro_c = b_off_q;
          rs_c = b_span_q;
        end
      end
      KIND_REMOVE: begin
        dai_c = at_idx_q;
        if (off_q == '0 || !at_f_q) begin
          st_c = STATUS_MISS;
        end else begin
          da_c = 1'b1;
          ro_c = off_q;
          rs_c = at_span_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      st_q   <= st_c;
      ro_q   <= ro_c;
      rs_q   <= rs_c;
      slot_q <= slot_c;
      dai_q  <= dai_c;
      dbi_q  <= dbi_c;
    end
  end

  // held count after this request
  always_comb begin
    held_d = held_q - CNT_W'(da_q) - CNT_W'(db_q) + CNT_W'(wr_q);
  end

  // valid bits after this request, the stored extent last
  always_comb begin
    valid_d = valid_q;
    if (da_q) valid_d[dai_q] = 1'b0;
    if (db_q) valid_d[dbi_q] = 1'b0;
    if (wr_q) valid_d[slot_q] = 1'b1;
  end

  // commit into the table state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      ins_cnt_q <= '0;
      held_q    <= '0;
      wr_q      <= 1'b0;
      da_q      <= 1'b0;
      db_q      <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      done_q <= cmd_i.commit;
      if (cmd_i.eval) begin
        wr_q <= wr_c;
        da_q <= da_c;
        db_q <= db_c;
      end
      if (cmd_i.commit) begin
        held_q  <= held_d;
        valid_q <= valid_d;
        if (wr_q) begin
          ins_cnt_q <= ins_cnt_q + 32'd1;
        end
      end
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_st_q   <= st_q;
      out_off_q  <= ro_q;
      out_span_q <= rs_q;
    end
  end

  assign done_o          = done_q;
  assign status_o        = out_st_q;
  assign result_offset_o = out_off_q;
  assign result_span_o   = out_span_q;
  assign entry_count_o   = held_q;

endmodule

// File: sv/coalescing_free_extent_table_core.sv
// ----------------------------------------------------------------------------
// coalescing_free_extent_table_core
// Best fit free extent table with coalescing of adjacent extents.
// ----------------------------------------------------------------------------
// a word accepted while idle is answered once the scan, drain, eval and commit
// states are through, done_o high for one cycle; no new word is taken before
// the answer, as the scan reads one entry per cycle through the table RAM port.
// the receiver cannot stall; a new word may be started in the done_o cycle.
// reset clears all valid bits, the stamp counter and the held count at once.
module coalescing_free_extent_table_core import cfet_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       kind_i,
  input  logic [31:0]      extent_offset_i,
  input  logic [31:0]      extent_span_i,
  output logic             done_o,
  output logic [2:0]       status_o,
  output logic [31:0]      result_offset_o,
  output logic [31:0]      result_span_o,
  output logic [CNT_W-1:0] entry_count_o
);

  cmd_t  cmd;
  stat_t stat;

  cfet_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  cfet_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .kind_i          (kind_i),
    .extent_offset_i (extent_offset_i),
    .extent_span_i   (extent_span_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .result_offset_o (result_offset_o),
    .result_span_o   (result_span_o),
    .entry_count_o   (entry_count_o)
  );

endmodule

// File: sv/cfet_checker.sv
// ----------------------------------------------------------------------------
// cfet_checker
// Port level checks of the extent table core, bound to the top level.
// ----------------------------------------------------------------------------
module cfet_checker import cfet_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             done_o,
  input logic [2:0]       status_o,
  input logic [31:0]      result_offset_o,
  input logic [31:0]      result_span_o,
  input logic [CNT_W-1:0] entry_count_o
);

  // an accepted word makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accept did not raise busy");

  // a result comes when the work is over
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result while busy");

  // a failed request carries no extent
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != STATUS_OK |-> result_offset_o == '0 && result_span_o == '0)
    else $error("failed request returned an extent");

  // held count never exceeds the table
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_count_o <= CNT_W'(TABLE_ENTRIES)) else $error("held count too large");

  // held count moves only with a result
  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o && $past(!done_o) && busy |=> $stable(entry_count_o) || done_o)
    else $error("held count changed without a result");

endmodule

bind coalescing_free_extent_table_core cfet_checker u_cfet_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .done_o          (done_o),
  .status_o        (status_o),
  .result_offset_o (result_offset_o),
  .result_span_o   (result_span_o),
  .entry_count_o   (entry_count_o)
);

// File: test/coalescing_free_extent_table_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// coalescing_free_extent_table_core_tb
// Self-checking bench for the free extent table: frees with coalescing, best
// fit allocation with oldest-first ties and removal, against a local table
// model; every answer word is compared field by field in order.
// ----------------------------------------------------------------------------
module coalescing_free_extent_table_core_tb;
  import cfet_pkg::*;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic [1:0]       kind_i;
  logic [31:0]      extent_offset_i;
  logic [31:0]      extent_span_i;
  logic             done_o;
  logic [2:0]       status_o;
  logic [31:0]      result_offset_o;
  logic [31:0]      result_span_o;
  logic [CNT_W-1:0] entry_count_o;

  typedef struct packed {
    status_e          st;
    logic [31:0]      offs;
    logic [31:0]      span;
    logic [CNT_W-1:0] cnt;
  } answer_t;

  // table model
  logic        tv [TABLE_ENTRIES];
  logic [31:0] toff [TABLE_ENTRIES];
  logic [31:0] tspan [TABLE_ENTRIES];
  logic [31:0] tstamp [TABLE_ENTRIES];
  logic [31:0] stamp_ctr;
  int unsigned held;

  answer_t pending_answers[$];
  int unsigned mismatches;
  int unsigned answers_seen;
  int unsigned words_sent;
  int unsigned cycle_count;
  int unsigned idle_pct;

  coalescing_free_extent_table_core dut (.*);

  // clock
  always begin
    clk_i = 1'b0; #5;
    clk_i = 1'b1; #5;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 600000) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int find_at(logic [31:0] o);
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (tv[i] && toff[i] == o) return i;
    return -1;
  endfunction

  function automatic void store_extent(logic [31:0] o, logic [31:0] s);
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (!tv[i]) begin
        tv[i] = 1'b1; toff[i] = o; tspan[i] = s; tstamp[i] = stamp_ctr;
        stamp_ctr++; held++;
        return;
      end
  endfunction

  function automatic answer_t predict_answer(kind_e k, logic [31:0] o, logic [31:0] s);
    answer_t a;
    int lo, hi, b;
    logic jl, jh;
    logic [31:0] no, ns;
    lo = -1; hi = -1; b = -1;
    a.st = STATUS_OK; a.offs = '0; a.span = '0;
    case (k)
      KIND_FREE: begin
        if (o == 0 || s == 0) a.st = STATUS_ZERO;
        else if ({1'b0, o} + {1'b0, s} > 33'hFFFFFFFF) a.st = STATUS_OVERLAP;
        else if (find_at(o) >= 0) a.st = STATUS_OVERLAP;
        else begin
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (tv[i] && toff[i] < o && (lo < 0 || toff[i] > toff[lo])) lo = i;
            if (tv[i] && toff[i] > o && (hi < 0 || toff[i] < toff[hi])) hi = i;
          end
          if (lo >= 0 && {1'b0, toff[lo]} + {1'b0, tspan[lo]} > {1'b0, o})
            a.st = STATUS_OVERLAP;
          else if (hi >= 0 && {1'b0, o} + {1'b0, s} > {1'b0, toff[hi]})
            a.st = STATUS_OVERLAP;
          else begin
            jl = lo >= 0 && toff[lo] + tspan[lo] == o;
            jh = hi >= 0 && o + s == toff[hi];
            if (!jl && !jh && held >= TABLE_ENTRIES) a.st = STATUS_FULL;
            else begin
              no = o; ns = s;
              if (jh) begin ns += tspan[hi]; tv[hi] = 1'b0; held--; end
              if (jl) begin ns += tspan[lo]; no = toff[lo]; tv[lo] = 1'b0; held--; end
              store_extent(no, ns);
              a.offs = no; a.span = ns;
            end
          end
        end
      end
      KIND_ALLOC: begin
        if (s == 0) a.st = STATUS_ZERO;
        else begin
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!tv[i] || tspan[i] < s) continue;
            if (b < 0 || tspan[i] < tspan[b] || (tspan[i] == tspan[b] &&
                (stamp_ctr - tstamp[i]) > (stamp_ctr - tstamp[b]))) b = i;
          end
          if (b < 0) a.st = STATUS_NO_FIT;
          else begin
            a.offs = toff[b]; a.span = tspan[b]; tv[b] = 1'b0; held--;
          end
        end
      end
      KIND_REMOVE: begin
        b = find_at(o);
        if (o == 0 || b < 0) a.st = STATUS_MISS;
        else begin
          a.offs = toff[b]; a.span = tspan[b]; tv[b] = 1'b0; held--;
        end
      end
      default: ;
    endcase
    a.cnt = held[CNT_W-1:0];
    return a;
  endfunction

  // answer checker
  always @(posedge clk_i) begin
    answer_t e;
    if (rst_ni && done_o) begin
      answers_seen++;
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected answer word, status %0d", status_o);
      end else begin
        e = pending_answers.pop_front();
        if (status_o !== e.st || result_offset_o !== e.offs ||
            result_span_o !== e.span || entry_count_o !== e.cnt) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st %0d off %h span %h cnt %0d, got st %0d off %h span %h cnt %0d",
                     e.st, e.offs, e.span, e.cnt, status_o, result_offset_o,
                     result_span_o, entry_count_o);
        end
      end
    end
  end

  // send one request word
  task automatic send_word(kind_e k, logic [31:0] o, logic [31:0] s);
    while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    start <= 1'b1; kind_i <= k; extent_offset_i <= o; extent_span_i <= s;
    do @(posedge clk_i); while (busy);
    pending_answers.push_back(predict_answer(k, o, s));
    words_sent++;
    start <= 1'b0;
    // the block stays busy after an accept
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_answers.size() != 0) @(posedge clk_i);
  endtask

  // extremes, zero arguments, overlaps, misses and the unused kind
  task automatic test_directed();
    send_word(KIND_ALLOC, 32'h0, 32'h5);
    send_word(KIND_FREE, 32'h0, 32'h10);
    send_word(KIND_FREE, 32'h100, 32'h0);
    send_word(KIND_ALLOC, 32'h0, 32'h0);
    send_word(KIND_FREE, 32'hFFFFFFF0, 32'h10);
    send_word(KIND_FREE, 32'hFFFFFFFF, 32'h1);
    send_word(KIND_FREE, 32'hFFFFFFFE, 32'h1);
    send_word(KIND_FREE, 32'h100, 32'h10);
    send_word(KIND_FREE, 32'h100, 32'h4);
    send_word(KIND_FREE, 32'h108, 32'h4);
    send_word(KIND_FREE, 32'hF8, 32'h10);
    send_word(KIND_FREE, 32'h120, 32'h10);
    send_word(KIND_FREE, 32'h110, 32'h10);
    send_word(KIND_FREE, 32'h80, 32'h80);
    send_word(KIND_FREE, 32'h1, 32'h7F);
    send_word(KIND_ALLOC, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_word(KIND_NONE, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_word(KIND_REMOVE, 32'h0, 32'h0);
    send_word(KIND_REMOVE, 32'h55, 32'hFFFFFFFF);
    send_word(KIND_ALLOC, 32'h0, 32'h1);
    send_word(KIND_REMOVE, 32'hFFFFFFFE, 32'h0);
    send_word(KIND_ALLOC, 32'h0, 32'h1);
    send_word(KIND_ALLOC, 32'h0, 32'h1);
    wait_drained();
  endtask

  // fill all entries with equal spans, overflow, then drain oldest first
  task automatic test_full_table();
    for (int i = 0; i < TABLE_ENTRIES + 2; i++)
      send_word(KIND_FREE, 32'h1000 + 32'(i) * 32'h20, 32'h10);
    send_word(KIND_FREE, 32'h1010, 32'h10);
    for (int i = 0; i < TABLE_ENTRIES + 1; i++)
      send_word(KIND_ALLOC, $urandom, 32'h10);
    wait_drained();
  endtask

  // random mix on a small grid so extents meet, overlap and recur
  task automatic test_random(int unsigned n);
    logic [31:0] o, s;
    int unsigned r;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(99);
      o = 32'($urandom_range(1, 200)) * 32'h10;
      s = 32'($urandom_range(1, 6)) * 32'h10;
      if (r < 3) begin o = $urandom; s = $urandom; end
      else if (r < 5) begin o = 32'hFFFFFFFF - $urandom_range(64); s = $urandom_range(70); end
      else if (r < 7) s = $urandom_range(1, 40);
      if (r < 50) send_word(KIND_FREE, o, s);
      else if (r < 75) send_word(KIND_ALLOC, $urandom, ($urandom_range(9) == 0) ? $urandom : s);
      else if (r < 97) send_word(KIND_REMOVE, o, $urandom);
      else send_word(kind_e'($urandom_range(3)), $urandom, $urandom);
    end
  endtask

  initial begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      tv[i] = 1'b0; toff[i] = '0; tspan[i] = '0; tstamp[i] = '0;
    end
    stamp_ctr = '0; held = 0; mismatches = 0; answers_seen = 0;
    words_sent = 0; cycle_count = 0; idle_pct = 0;
    rst_ni = 1'b0; start = 1'b0; kind_i = '0;
    extent_offset_i = '0; extent_span_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct = 10;
    test_directed();
    test_full_table();
    test_random(500);
    idle_pct = 74;
    test_random(500);
    idle_pct = 0;
    test_random(500);

    wait_drained();
    repeat (TABLE_ENTRIES + 10) @(posedge clk_i);
    $display("covered %0d request words, %0d answer words checked", words_sent, answers_seen);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
